// ===== rtl/lkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, reset values and the cell interface types.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;
  localparam int CAP_RESET   = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [0:0] REG_CAPACITY = 1'b0;
  localparam logic [0:0] OP_GET       = 1'b0;
  localparam logic [0:0] OP_PUT       = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic cmp_en;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lkv_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One entry of the recency chain: compares its key against an incoming item
// and, when told, takes over the entry of its left neighbor.
// ----------------------------------------------------------------------------
module lkv_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lkv_pkg::cell_ctl_t         ctl_i,
  input  wire logic [lkv_pkg::KEY_W-1:0]  cmp_key_i,
  input  wire lkv_pkg::entry_t            prev_i,
  output lkv_pkg::entry_t                 entry_o,
  output logic                            match_o
);

  logic                      valid_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] value_q;
  logic                      match_q;
  logic                      match_d;

  assign match_d = valid_q && (key_q == cmp_key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl_i.shift) begin
        valid_q <= prev_i.valid;
      end
      if (ctl_i.cmp_en) begin
        match_q <= match_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = match_q;

endmodule
`default_nettype wire

// ===== rtl/lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache unit
// Fully associative key/value store with least-recently-used replacement.
//
// Command channel: an item (opcode_i, key_i, value_i) is taken at a clock
// edge where start is high and busy is low. opcode 0 reads by key, opcode 1
// writes the pair, evicting the least recent entry when capacity is reached.
// Result channel: done_o is high for one cycle with hit_o, read_value_o,
// evicted_o and evicted_key_o; the receiver cannot stall it.
// Timing: every cell compares its key in the cycle an item is taken, and the
// recency chain shifts in the cycle after, while busy is high. The result is
// registered, with done_o, at the end of the busy cycle; busy is high for one
// cycle, and no new item is taken while it is high. Entries sit in recency
// order: cell 0 is the most recent. Configuration: APB register 0 (byte
// address 0) holds capacity, written only while idle by the user; the block
// does not enforce it. Reset empties every cell and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lkv_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lkv_pkg::PDATA_W-1:0]   pwdata,
  output logic      [lkv_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode_i,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] key_i,
  input  wire logic signed [lkv_pkg::VAL_W-1:0] value_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic signed [lkv_pkg::VAL_W-1:0]   read_value_o,
  output logic                               evicted_o,
  output logic signed [lkv_pkg::KEY_W-1:0]   evicted_key_o
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic [OCC_W-1:0]          occ_q, occ_d;
  logic                      busy_q;
  logic                      op_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] value_q;

  logic                      done_q;
  logic                      hit_q;
  logic [lkv_pkg::VAL_W-1:0] rd_q;
  logic                      ev_q;
  logic [lkv_pkg::KEY_W-1:0] evk_q;

  logic                      accept;
  logic                      cfg_wr;
  logic [0:0]                reg_idx;

  lkv_pkg::entry_t           entry   [ENTRIES];
  lkv_pkg::entry_t           prev    [ENTRIES];
  lkv_pkg::cell_ctl_t        ctl     [ENTRIES];
  logic [ENTRIES-1:0]        match_vec;
  logic [ENTRIES-1:0]        valid_vec;
  logic [ENTRIES-1:0]        last_vec;
  logic [ENTRIES-1:0]        shift_mask;

  logic                      hit;
  logic [lkv_pkg::VAL_W-1:0] rd_val;
  logic [lkv_pkg::KEY_W-1:0] lru_key;
  logic [lkv_pkg::VAL_W-1:0] new_val;
  logic [CW-1:0]             cap_ext, cap_eff;
  logic                      can_insert;
  logic                      put_miss, do_insert, do_evict;

  assign accept  = start && !busy_q;
  assign reg_idx = paddr[lkv_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == lkv_pkg::REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == lkv_pkg::REG_CAPACITY)
                   ? lkv_pkg::PDATA_W'(cap_q) : '0;
  assign busy    = busy_q;

  // Cell chain
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev[g].valid = 1'b1;
      assign prev[g].key   = key_q;
      assign prev[g].value = new_val;
    end else begin : g_link
      assign prev[g] = entry[g-1];
    end
    assign ctl[g].cmp_en = accept;
    assign ctl[g].shift  = shift_mask[g];
    assign valid_vec[g]  = entry[g].valid;

    lkv_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[g]),
      .cmp_key_i (key_i),
      .prev_i    (prev[g]),
      .entry_o   (entry[g]),
      .match_o   (match_vec[g])
    );
  end

  assign last_vec = valid_vec & ~(valid_vec >> 1);
  assign hit      = |match_vec;

  always_comb begin
    rd_val  = '0;
    lru_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_val  = rd_val  | ({lkv_pkg::VAL_W{match_vec[i]}} & entry[i].value);
      lru_key = lru_key | ({lkv_pkg::KEY_W{last_vec[i]}}  & entry[i].key);
    end
  end

  assign new_val = (op_q == lkv_pkg::OP_PUT) ? value_q : rd_val;

  always_comb begin
    cap_ext = CW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign can_insert = CW'(occ_q) < cap_eff;
  assign put_miss   = (op_q == lkv_pkg::OP_PUT) && !hit;
  assign do_insert  = put_miss && can_insert;
  assign do_evict   = put_miss && !can_insert;

  always_comb begin
    shift_mask = '0;
    if (busy_q) begin
      if (hit) begin
        shift_mask = match_vec | (match_vec - ENTRIES'(1));
      end else if (do_insert) begin
        shift_mask = (valid_vec << 1) | ENTRIES'(1);
      end else if (do_evict) begin
        shift_mask = valid_vec;
      end
    end
  end

  assign occ_d = (busy_q && do_insert) ? occ_q + OCC_W'(1) : occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
      occ_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_q <= pwdata[lkv_pkg::CAP_W-1:0];
      end
      occ_q  <= occ_d;
      busy_q <= accept;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (busy_q) begin
      hit_q <= hit;
      rd_q  <= (hit && (op_q == lkv_pkg::OP_GET)) ? rd_val : '0;
      ev_q  <= do_evict;
      evk_q <= do_evict ? lru_key : '0;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

endmodule
`default_nettype wire

// ===== rtl/lkv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Port-level checks on item flow and result consistency.
// ----------------------------------------------------------------------------
module lkv_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       opcode_i,
  input wire logic                       done_o,
  input wire logic                       hit_o,
  input wire logic [lkv_pkg::VAL_W-1:0]  read_value_o,
  input wire logic                       evicted_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken without busy following");

  a_busy_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("result missing after busy cycle");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction reported together");

  a_evict_put : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> ($past(opcode_i, 2) == lkv_pkg::OP_PUT))
    else $error("eviction on a get");

  a_put_no_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(opcode_i, 2) == lkv_pkg::OP_PUT)) |-> (read_value_o == '0))
    else $error("read value on a put");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .opcode_i     (opcode_i),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .read_value_o (read_value_o),
  .evicted_o    (evicted_o)
);
`default_nettype wire

// ===== tb/tb_lru_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache unit testbench
// Drives get and put items with random gaps, mirrors the store in a shadow
// copy with recency ranks, and checks every result in order. A short table
// of directed items covers the field extremes, put hits and capacity corner
// settings. Randomized phases follow, each at its own capacity, using small
// key pools so that hits and evictions are frequent.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;

  localparam int KEY_W     = lkv_pkg::KEY_W;
  localparam int VAL_W     = lkv_pkg::VAL_W;
  localparam int CAP_W     = lkv_pkg::CAP_W;
  localparam int PADDR_W   = lkv_pkg::PADDR_W;
  localparam int PDATA_W   = lkv_pkg::PDATA_W;
  localparam logic OP_GET  = lkv_pkg::OP_GET;
  localparam logic OP_PUT  = lkv_pkg::OP_PUT;

  localparam int NUM_CELLS    = lkv_pkg::ENTRIES_DEF;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int NUM_PHASES   = 8;
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(lkv_pkg::REG_CAPACITY));

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lookup_result_t;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CAP} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CAP_W-1:0] cap;
    bit               pinned;
    lookup_result_t   want;
  } stim_row_t;

  localparam lookup_result_t MISS = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = OP_GET;
  logic signed [KEY_W-1:0] key_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic done_o;
  logic hit_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic evicted_o;
  logic signed [KEY_W-1:0] evicted_key_o;

  logic pin_valid = 1'b0;
  lookup_result_t pin_result = '0;

  logic [KEY_W-1:0] cell_key [NUM_CELLS];
  logic [VAL_W-1:0] cell_value [NUM_CELLS];
  bit cell_valid [NUM_CELLS];
  int unsigned cell_rank [NUM_CELLS];
  int unsigned fill_count;
  logic [CAP_W-1:0] cap_setting;

  lookup_result_t due_results [$];
  stim_row_t directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  lru_key_value_cache_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  function automatic void promote_cell(int idx, bit was_valid);
    int unsigned old_rank;
    old_rank = was_valid ? cell_rank[idx] : 32'hFFFF_FFFF;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (i != idx && cell_valid[i] && cell_rank[i] < old_rank) begin
        cell_rank[i]++;
      end
    end
    cell_rank[idx] = 0;
  endfunction

  function automatic lookup_result_t apply_request(logic op, logic [KEY_W-1:0] key,
                                                   logic [VAL_W-1:0] value);
    lookup_result_t res;
    int unsigned cap;
    int unsigned oldest;
    int found;
    int slot;
    res = '0;
    cap = cap_setting;
    if (cap == 0) cap = 1;
    if (cap > NUM_CELLS) cap = NUM_CELLS;
    found = -1;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (cell_valid[i] && cell_key[i] == key && found < 0) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (op == OP_GET) begin
        res.read_value = cell_value[found];
      end else begin
        cell_value[found] = value;
      end
      promote_cell(found, 1'b1);
    end else if (op == OP_PUT) begin
      slot = -1;
      if (fill_count < cap) begin
        for (int i = 0; i < NUM_CELLS; i++) begin
          if (!cell_valid[i] && slot < 0) slot = i;
        end
      end
      if (slot >= 0) begin
        promote_cell(slot, 1'b0);
        cell_valid[slot] = 1'b1;
        fill_count++;
      end else begin
        oldest = 0;
        for (int i = 0; i < NUM_CELLS; i++) begin
          if (cell_valid[i] && (slot < 0 || cell_rank[i] > oldest)) begin
            slot = i;
            oldest = cell_rank[i];
          end
        end
        res.evicted = 1'b1;
        res.evicted_key = cell_key[slot];
        promote_cell(slot, 1'b1);
      end
      cell_key[slot] = key;
      cell_value[slot] = value;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, lookup_result_t want_r, lookup_result_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: want hit=%0b rd=%h ev=%0b evk=%h, got hit=%0b rd=%h ev=%0b evk=%h",
               $realtime, what, want_r.hit, want_r.read_value, want_r.evicted,
               want_r.evicted_key, got_r.hit, got_r.read_value, got_r.evicted,
               got_r.evicted_key);
    end
  endtask

  always @(posedge clk_i) begin
    lookup_result_t seen;
    lookup_result_t want;
    lookup_result_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        seen = {hit_o, read_value_o, evicted_o, evicted_key_o};
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", MISS, seen);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (seen !== want) report_mismatch("result mismatch", want, seen);
        end
      end
      if (start && !busy) begin
        predicted = apply_request(opcode_i, key_i, value_i);
        due_results.insert(due_results.size(), pin_valid ? pin_result : predicted);
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        cap_setting = pwdata[CAP_W-1:0];
      end
      if ((start && !busy) || done_o || (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[lru_key_value_cache_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic issue_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                               bit pinned, lookup_result_t typed);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    value_i    <= value;
    pin_valid  <= pinned;
    pin_result <= typed;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {(PDATA_W-CAP_W)'($urandom()), cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic stim_row_t item_row(logic op, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] value, bit pinned,
                                         lookup_result_t want);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.key = key;
    r.value = value;
    r.cap = '0;
    r.pinned = pinned;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cap_row(logic [CAP_W-1:0] cap);
    stim_row_t r;
    r = item_row(OP_GET, '0, '0, 1'b0, MISS);
    r.kind = ROW_CAP;
    r.cap = cap;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  initial begin
    logic [KEY_W-1:0] key_pool [$];
    logic [CAP_W-1:0] phase_caps [NUM_PHASES];
    logic [KEY_W-1:0] key;
    int unsigned eff_cap;
    int unsigned pool_size;

    for (int i = 0; i < NUM_CELLS; i++) begin
      cell_key[i] = '0;
      cell_value[i] = '0;
      cell_valid[i] = 1'b0;
      cell_rank[i] = 0;
    end
    fill_count = 0;
    cap_setting = CAP_W'(lkv_pkg::CAP_RESET);

    add_row(item_row(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS));
    add_row(item_row(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, MISS));
    add_row(item_row(OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
                     {1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}));
    add_row(item_row(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MISS));
    add_row(item_row(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
                     {1'b1, 32'h8000_0000, 1'b0, 32'h0}));
    add_row(item_row(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, MISS));
    add_row(item_row(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                     {1'b1, 32'h0, 1'b0, 32'h0}));
    add_row(item_row(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                     {1'b1, 32'h0, 1'b0, 32'h0}));
    add_row(item_row(OP_GET, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, MISS));
    add_row(cap_row(5'd1));
    add_row(item_row(OP_PUT, 32'd5, 32'd55, 1'b0, MISS));
    add_row(item_row(OP_PUT, 32'd6, 32'd66, 1'b0, MISS));
    add_row(item_row(OP_GET, 32'd5, 32'd0, 1'b0, MISS));
    add_row(cap_row(5'd0));
    add_row(item_row(OP_PUT, 32'd7, 32'd77, 1'b0, MISS));
    add_row(item_row(OP_GET, 32'd6, 32'd0, 1'b0, MISS));
    add_row(cap_row(5'd31));
    add_row(item_row(OP_PUT, 32'd8, 32'h5555_5555, 1'b0, MISS));
    add_row(item_row(OP_PUT, 32'd9, 32'hAAAA_AAAA, 1'b0, MISS));
    add_row(item_row(OP_GET, 32'd7, 32'd0, 1'b0, MISS));
    add_row(item_row(OP_PUT, 32'd7, 32'd0, 1'b0, MISS));
    add_row(item_row(OP_GET, 32'd9, 32'd0, 1'b0, MISS));
    add_row(cap_row(5'd16));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAP) begin
        set_capacity(directed_rows[i].cap);
      end else begin
        issue_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                      directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd5, 5'd16, 5'd0};
    phase_caps[NUM_PHASES-1] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_caps[p]);
      eff_cap = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > NUM_CELLS ? NUM_CELLS
                                                                      : phase_caps[p]);
      pool_size = eff_cap + $urandom_range(1, 6);
      key_pool.delete();
      for (int k = 0; k < pool_size; k++) begin
        case ($urandom_range(0, 9))
          0: key_pool.insert(key_pool.size(), 32'h0000_0000);
          1: key_pool.insert(key_pool.size(), 32'hFFFF_FFFF);
          2: key_pool.insert(key_pool.size(), 32'h8000_0000);
          3: key_pool.insert(key_pool.size(), 32'h7FFF_FFFF);
          default: key_pool.insert(key_pool.size(), $urandom());
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_gaps = (n % 60) < 15;
        key = ($urandom_range(0, 9) == 0) ? $urandom()
                                          : key_pool[$urandom_range(0, pool_size - 1)];
        issue_request(($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET, key, $urandom(),
                      1'b0, MISS);
      end
      no_gaps = 1'b0;
    end

    wait_drained();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("[lru_key_value_cache_unit] OK");
    end else begin
      $display("[lru_key_value_cache_unit] ERROR");
    end
    $finish;
  end

endmodule
